FILE: hw/rtl/assert_macros.svh
// Assertion macros shared by the frame parser modules
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef NO_ASSERTIONS
`define ASSERT_IMPLY(label, clk, rst, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);
`define ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);
`else
`define ASSERT_IMPLY(label, clk, rst, ante, cons, msg)
`define ASSERT_NEXT(label, clk, rst, ante, cons, msg)
`endif
`endif

FILE: hw/rtl/lfp_pkg.sv
// Types, constants and CRC function for the frame parser
`default_nettype none
package lfp_pkg;

  localparam logic [15:0] CRC_INIT = 16'hFFFF;
  localparam logic [15:0] CRC_POLY = 16'hA001;

  localparam logic [15:0] OFS_DIST_LO = 16'd6;
  localparam logic [15:0] OFS_DIST_HI = 16'd7;
  localparam logic [15:0] OFS_QUAL_LO = 16'd10;
  localparam logic [15:0] OFS_QUAL_HI = 16'd11;

  localparam logic [7:0] REG_HEAD_FLAG     = 8'd0;
  localparam logic [7:0] REG_DEVICE_NUMBER = 8'd1;
  localparam logic [7:0] REG_DEVICE_TYPE   = 8'd2;
  localparam logic [7:0] REG_COMMAND_WORD  = 8'd3;
  localparam logic [7:0] REG_RESERVED_BYTE = 8'd4;

  typedef enum logic [3:0] {
    PH_HDR0    = 4'd0,
    PH_HDR1    = 4'd1,
    PH_HDR2    = 4'd2,
    PH_HDR3    = 4'd3,
    PH_HDR4    = 4'd4,
    PH_LEN_HI  = 4'd5,
    PH_LEN_LO  = 4'd6,
    PH_PAYLOAD = 4'd7,
    PH_CRC_HI  = 4'd8,
    PH_CRC_LO  = 4'd9
  } phase_t;

  typedef struct packed {
    logic [7:0] head_flag;
    logic [7:0] device_number;
    logic [7:0] device_type;
    logic [7:0] command_word;
    logic [7:0] reserved_byte;
  } cfg_t;

  typedef struct packed {
    logic [15:0] payload_length;
    logic [15:0] quality;
    logic [15:0] distance;
    logic        frame_status;
  } frame_report_t;

  function automatic logic [15:0] crc_byte(input logic [15:0] crc_in, input logic [7:0] b);
    logic [15:0] c;
    c = crc_in ^ {8'h00, b};
    for (int k = 0; k < 8; k++) begin
      if (c[0]) begin
        c = (c >> 1) ^ CRC_POLY;
      end else begin
        c = c >> 1;
      end
    end
    return c;
  endfunction

endpackage
`default_nettype wire

FILE: hw/rtl/lfp_cfg.sv
// Configuration register file for the expected header bytes
`default_nettype none
module lfp_cfg (
  input  wire logic         clk,
  input  wire logic         rst,
  input  wire logic         cfg_valid,
  output logic              cfg_ready,
  input  wire logic [7:0]   cfg_index,
  input  wire logic [7:0]   cfg_data,
  output lfp_pkg::cfg_t     cfg
);

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg <= '0;
    end else if (cfg_valid) begin
      unique case (cfg_index)
        lfp_pkg::REG_HEAD_FLAG:     cfg.head_flag     <= cfg_data;
        lfp_pkg::REG_DEVICE_NUMBER: cfg.device_number <= cfg_data;
        lfp_pkg::REG_DEVICE_TYPE:   cfg.device_type   <= cfg_data;
        lfp_pkg::REG_COMMAND_WORD:  cfg.command_word  <= cfg_data;
        lfp_pkg::REG_RESERVED_BYTE: cfg.reserved_byte <= cfg_data;
        default: ;
      endcase
    end
  end

endmodule
`default_nettype wire

FILE: hw/rtl/lfp_parse.sv
// Header match, length count and CRC state for one received byte per cycle while in_fire is high
`default_nettype none
`include "assert_macros.svh"
module lfp_parse (
  input  wire logic                clk,
  input  wire logic                rst,
  input  wire logic                in_fire,
  input  wire logic [7:0]          rx_byte,
  input  wire lfp_pkg::cfg_t       cfg,
  output logic                     res_valid,
  output lfp_pkg::frame_report_t   res
);

  lfp_pkg::phase_t phase, phase_next;
  logic [15:0] length_value, length_value_next;
  logic [15:0] byte_count, byte_count_next;
  logic [15:0] running_crc, running_crc_next;
  logic [7:0]  received_crc_high, received_crc_high_next;
  logic [15:0] distance_hold, distance_hold_next;
  logic [15:0] quality_hold, quality_hold_next;

  logic [7:0]  expected;
  logic [15:0] crc_base;
  logic [15:0] crc_upd;
  logic [15:0] count_inc;
  logic        crc_ok;

  always_comb begin
    unique case (phase)
      lfp_pkg::PH_HDR0: expected = cfg.head_flag;
      lfp_pkg::PH_HDR1: expected = cfg.device_number;
      lfp_pkg::PH_HDR2: expected = cfg.device_type;
      lfp_pkg::PH_HDR3: expected = cfg.command_word;
      default:          expected = cfg.reserved_byte;
    endcase
  end

  assign crc_base  = (phase == lfp_pkg::PH_HDR0) ? lfp_pkg::CRC_INIT : running_crc;
  assign crc_upd   = lfp_pkg::crc_byte(crc_base, rx_byte);
  assign count_inc = byte_count + 16'd1;
  assign crc_ok    = ({received_crc_high, rx_byte} == running_crc);

  always_comb begin
    phase_next             = phase;
    length_value_next      = length_value;
    byte_count_next        = byte_count;
    running_crc_next       = running_crc;
    received_crc_high_next = received_crc_high;
    distance_hold_next     = distance_hold;
    quality_hold_next      = quality_hold;
    res_valid              = 1'b0;
    res.frame_status       = ~crc_ok;
    res.distance           = crc_ok ? distance_hold : 16'd0;
    res.quality            = crc_ok ? quality_hold : 16'd0;
    res.payload_length     = length_value;
    if (in_fire) begin
      unique case (phase)
        lfp_pkg::PH_HDR0, lfp_pkg::PH_HDR1, lfp_pkg::PH_HDR2,
        lfp_pkg::PH_HDR3, lfp_pkg::PH_HDR4: begin
          if (rx_byte != expected) begin
            phase_next = lfp_pkg::PH_HDR0;
          end else begin
            if (phase == lfp_pkg::PH_HDR0) begin
              distance_hold_next = 16'd0;
              quality_hold_next  = 16'd0;
              length_value_next  = 16'd0;
              byte_count_next    = 16'd0;
            end
            running_crc_next = crc_upd;
            phase_next       = lfp_pkg::phase_t'(phase + 4'd1);
          end
        end
        lfp_pkg::PH_LEN_HI: begin
          length_value_next = {rx_byte, 8'h00};
          running_crc_next  = crc_upd;
          phase_next        = lfp_pkg::PH_LEN_LO;
        end
        lfp_pkg::PH_LEN_LO: begin
          length_value_next = {length_value[15:8], rx_byte};
          running_crc_next  = crc_upd;
          byte_count_next   = 16'd0;
          phase_next        = ({length_value[15:8], rx_byte} == 16'd0) ?
                              lfp_pkg::PH_CRC_HI : lfp_pkg::PH_PAYLOAD;
        end
        lfp_pkg::PH_PAYLOAD: begin
          running_crc_next = crc_upd;
          if (byte_count == lfp_pkg::OFS_DIST_LO) distance_hold_next[7:0]  = rx_byte;
          if (byte_count == lfp_pkg::OFS_DIST_HI) distance_hold_next[15:8] = rx_byte;
          if (byte_count == lfp_pkg::OFS_QUAL_LO) quality_hold_next[7:0]   = rx_byte;
          if (byte_count == lfp_pkg::OFS_QUAL_HI) quality_hold_next[15:8]  = rx_byte;
          byte_count_next = count_inc;
          if (count_inc == length_value) phase_next = lfp_pkg::PH_CRC_HI;
        end
        lfp_pkg::PH_CRC_HI: begin
          received_crc_high_next = rx_byte;
          phase_next             = lfp_pkg::PH_CRC_LO;
        end
        lfp_pkg::PH_CRC_LO: begin
          res_valid  = 1'b1;
          phase_next = lfp_pkg::PH_HDR0;
        end
        default: begin
          phase_next = lfp_pkg::PH_HDR0;
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      phase             <= lfp_pkg::PH_HDR0;
      length_value      <= 16'd0;
      byte_count        <= 16'd0;
      running_crc       <= lfp_pkg::CRC_INIT;
      received_crc_high <= 8'd0;
      distance_hold     <= 16'd0;
      quality_hold      <= 16'd0;
    end else begin
      phase             <= phase_next;
      length_value      <= length_value_next;
      byte_count        <= byte_count_next;
      running_crc       <= running_crc_next;
      received_crc_high <= received_crc_high_next;
      distance_hold     <= distance_hold_next;
      quality_hold      <= quality_hold_next;
    end
  end

  `ASSERT_IMPLY(a_res_at_crc_lo, clk, rst, res_valid, in_fire && (phase == lfp_pkg::PH_CRC_LO), "result outside last crc byte")
  `ASSERT_IMPLY(a_count_below_len, clk, rst, phase == lfp_pkg::PH_PAYLOAD, byte_count < length_value, "payload count past length")
  `ASSERT_NEXT(a_hdr_miss_restart, clk, rst, in_fire && (phase <= lfp_pkg::PH_HDR4) && (rx_byte != expected), phase == lfp_pkg::PH_HDR0, "header mismatch did not restart")

endmodule
`default_nettype wire

FILE: hw/rtl/lfp_out.sv
// Result register on the master side
`default_nettype none
`include "assert_macros.svh"
module lfp_out (
  input  wire logic                    clk,
  input  wire logic                    rst,
  input  wire logic                    res_valid,
  input  wire lfp_pkg::frame_report_t  res,
  output logic                         space,
  output logic                         m_tvalid,
  input  wire logic                    m_tready,
  output logic [55:0]                  m_tdata
);

  lfp_pkg::frame_report_t hold;

  assign space   = ~m_tvalid | m_tready;
  assign m_tdata = {7'd0, hold};

  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (res_valid) begin
      m_tvalid <= 1'b1;
    end else if (m_tready) begin
      m_tvalid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (res_valid) begin
      hold <= res;
    end
  end

  `ASSERT_IMPLY(a_no_overwrite, clk, rst, res_valid, space, "result loaded over a pending item")

endmodule
`default_nettype wire

FILE: hw/rtl/lidar_frame_parser_crc16_unit.sv
// Top level: frame parser with CRC-16/MODBUS check on a byte stream
// Throughput: one received byte per cycle, sustained, while the result side drains.
// The result appears on m_tvalid in the cycle after the last CRC byte is taken.
// The result register frees its slot in the same cycle it is taken, so input never waits
// on a draining result; s_tready drops only while an untaken result is held.
// Reset (rst, synchronous): header hunt at byte zero, CRC at 0xFFFF, other registers zero but the result data hold.
`default_nettype none
module lidar_frame_parser_crc16_unit (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        s_tvalid,
  output logic             s_tready,
  input  wire logic [7:0]  s_tdata,   // [7:0] rx_byte
  output logic             m_tvalid,
  input  wire logic        m_tready,
  output logic [55:0]      m_tdata,   // [0] frame_status, [16:1] distance, [32:17] quality,
                                      // [48:33] payload_length, [55:49] zero
  input  wire logic        cfg_valid,
  output logic             cfg_ready,
  input  wire logic [7:0]  cfg_index,
  input  wire logic [7:0]  cfg_data
);

  lfp_pkg::cfg_t          cfg;
  lfp_pkg::frame_report_t res;
  logic                   res_valid;
  logic                   space;
  logic                   in_fire;

  assign s_tready = space;
  assign in_fire  = s_tvalid & s_tready;

  lfp_cfg u_cfg (
    .clk       (clk),
    .rst       (rst),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .cfg       (cfg)
  );

  lfp_parse u_parse (
    .clk       (clk),
    .rst       (rst),
    .in_fire   (in_fire),
    .rx_byte   (s_tdata),
    .cfg       (cfg),
    .res_valid (res_valid),
    .res       (res)
  );

  lfp_out u_out (
    .clk       (clk),
    .rst       (rst),
    .res_valid (res_valid),
    .res       (res),
    .space     (space),
    .m_tvalid  (m_tvalid),
    .m_tready  (m_tready),
    .m_tdata   (m_tdata)
  );

endmodule
`default_nettype wire
